// ===== rtl/core/sha256mh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Round constants, standard initial words and a shared rotate-right function.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256mh_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    // Control from sequencer to round unit
    typedef struct packed {
        logic       load;      // copy hash words into working vars
        logic       round;     // run one round
        logic       fold;      // add working vars into hash words
        logic       init;      // load hash words from init registers
        logic [5:0] rnd;       // round index
    } rnd_ctrl_t;

    localparam word_t STD_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256mh_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Rolling 16-word schedule, working variables and hash words; one round
// per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256mh_round (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sha256mh_pkg::rnd_ctrl_t ctrl,
    input  wire logic                   w_we,       // schedule word write
    input  wire logic [3:0]             w_addr,
    input  wire sha256mh_pkg::word_t    w_data,
    input  wire sha256mh_pkg::word_t    init_words [8],
    output sha256mh_pkg::word_t         hash_words [8]
);

    sha256mh_pkg::word_t w_reg [16];
    sha256mh_pkg::word_t v_reg [8];
    sha256mh_pkg::word_t h_reg [8];

    sha256mh_pkg::word_t w15, w2, w7, w_cur, wt, t1, t2, s0, s1;
    logic [3:0] r4;

    // Schedule expansion and round function
    always_comb
    begin
        r4    = ctrl.rnd[3:0];
        w15   = w_reg[r4 + 4'd1];
        w2    = w_reg[r4 + 4'd14];
        w7    = w_reg[r4 + 4'd9];
        w_cur = w_reg[r4];
        s0 = sha256mh_pkg::rotr(w15, 7) ^ sha256mh_pkg::rotr(w15, 18) ^ (w15 >> 3);
        s1 = sha256mh_pkg::rotr(w2, 17) ^ sha256mh_pkg::rotr(w2, 19) ^ (w2 >> 10);
        wt = (ctrl.rnd >= 6'd16) ? (w_cur + s0 + w7 + s1) : w_cur;
        t1 = v_reg[7]
           + (sha256mh_pkg::rotr(v_reg[4], 6) ^ sha256mh_pkg::rotr(v_reg[4], 11)
              ^ sha256mh_pkg::rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256mh_pkg::ROUND_K[ctrl.rnd] + wt;
        t2 = (sha256mh_pkg::rotr(v_reg[0], 2) ^ sha256mh_pkg::rotr(v_reg[0], 13)
              ^ sha256mh_pkg::rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Schedule storage: host words, then expanded words in place
    always_ff @(posedge clk)
    begin
        if (w_we)
            w_reg[w_addr] <= w_data;
        else if (ctrl.round)
            w_reg[r4] <= wt;
    end

    // Working variables and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= '0;
                h_reg[i] <= sha256mh_pkg::STD_INIT[i];
            end
        end
        else
        begin
            if (ctrl.init)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= init_words[i];
            else if (ctrl.fold)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (ctrl.load)
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            else if (ctrl.round)
            begin
                for (int i = 1; i < 8; i++)
                    v_reg[i] <= v_reg[i-1];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[0] <= t1 + t2;
            end
        end
    end

    assign hash_words = h_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sha256_message_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a word stream with padding and length; one digest per message.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata[31:0] data_word, [34:32] byte_count; tlast last_word
// m_axis    out  tdata 4 x 64 digest pairs, high pair lowest; tuser length_overflow
// cfg       in   init_word_0..7 at index 0..7
//
// A plain word goes straight into the schedule; a word that completes a block
// also runs the shared round unit (load, 64 rounds, fold). A last word
// runs padding: one word per cycle, then load, rounds and fold per block,
// one or two blocks, then a move of the digest into the output register.
// s_tready is low during padding, while the round unit runs or while a
// finished digest waits for the output register to free up. Reset loads
// the standard initial words. The output register holds while m_tready is
// low, and the next message may start meanwhile.
`default_nettype none
module sha256_message_hasher_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // data_word[31:0], byte_count[34:32]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata,   // high pair, second, third, low pair
    output logic              m_tuser,   // length_overflow
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_PAD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    sha256mh_pkg::word_t init_reg [8];
    sha256mh_pkg::word_t hash_w [8];
    sha256mh_pkg::rnd_ctrl_t ctrl;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  idx_reg;
    logic [5:0]  rnd_reg;
    logic [32:0] total_reg;
    logic        pad_reg;       // padding in progress
    logic        extra_reg;     // 0x80 word still owed after a full last word
    logic        tail_zero_reg; // marker sits in slot 14: length goes to next block
    logic        len_done_reg;  // length words written, last block in flight
    logic        accept;
    logic [2:0]  cnt;
    logic [32:0] total_sum;
    logic [32:0] total_new;
    sha256mh_pkg::word_t keep, word_in, pad_word;
    logic        we;
    sha256mh_pkg::word_t wdat;
    logic        out_load;
    logic        out_valid_reg;
    logic        ovf_reg;
    logic [255:0] digest_reg;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < 8; i++)
                init_reg[i] <= sha256mh_pkg::STD_INIT[i];
        else if (cfg_we)
            init_reg[cfg_index] <= cfg_data;
    end

    // Input word shaping and byte count
    always_comb
    begin
        cnt = (!s_tlast || s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
        case (cnt)
            3'd0:    keep = 32'h0000_0000;
            3'd1:    keep = 32'hff00_0000;
            3'd2:    keep = 32'hffff_0000;
            3'd3:    keep = 32'hffff_ff00;
            default: keep = 32'hffff_ffff;
        endcase
        case (cnt)
            3'd0:    pad_word = 32'h8000_0000;
            3'd1:    pad_word = 32'h0080_0000;
            3'd2:    pad_word = 32'h0000_8000;
            3'd3:    pad_word = 32'h0000_0080;
            default: pad_word = 32'h0;
        endcase
        word_in   = (s_tdata[31:0] & keep) | pad_word;
        total_sum = total_reg + {30'd0, cnt};
        total_new = total_sum[32] ? 33'h1_0000_0000 : total_sum;
    end

    // Pad word for the current slot
    sha256mh_pkg::word_t pad_fill;
    logic [34:0] bits;
    always_comb
    begin
        bits = {total_reg[31:0], 3'b000};
        if (tail_zero_reg)
            pad_fill = '0;
        else if (idx_reg == 4'd14)
            pad_fill = {29'd0, bits[34:32]};
        else if (idx_reg == 4'd15)
            pad_fill = bits[31:0];
        else
            pad_fill = '0;
    end

    // Sequencer
    logic count4_last;
    assign count4_last = (cnt == 3'd4);

    always_comb
    begin
        state_next = state_reg;
        we   = 1'b0;
        wdat = word_in;
        ctrl = '0;
        ctrl.rnd = rnd_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    we = 1'b1;
                    ctrl.init = (total_reg == 33'd0);
                    if (idx_reg == 4'd15)
                        state_next = ST_LOAD;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            ST_PAD:
            begin
                we   = 1'b1;
                wdat = extra_reg ? 32'h8000_0000 : pad_fill;
                if (idx_reg == 4'd15)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                ctrl.round = 1'b1;
                if (rnd_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                if (!pad_reg)
                    state_next = ST_IDLE;
                else if (len_done_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rnd_reg       <= '0;
            total_reg     <= '0;
            pad_reg       <= 1'b0;
            extra_reg     <= 1'b0;
            tail_zero_reg <= 1'b0;
            len_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (we)
                idx_reg <= idx_reg + 4'd1;
            if (state_reg == ST_RND)
                rnd_reg <= rnd_reg + 6'd1;
            if (accept)
            begin
                total_reg <= total_new;
                if (s_tlast)
                begin
                    pad_reg       <= 1'b1;
                    extra_reg     <= count4_last;
                    tail_zero_reg <= !count4_last && (idx_reg == 4'd14);
                end
            end
            else if (state_reg == ST_PAD)
            begin
                if (extra_reg)
                begin
                    extra_reg <= 1'b0;
                    if (idx_reg == 4'd14)
                        tail_zero_reg <= 1'b1;
                end
                else if (idx_reg == 4'd15 && !tail_zero_reg)
                    len_done_reg <= 1'b1;
            end
            else if (state_reg == ST_FOLD)
                tail_zero_reg <= 1'b0;
            if (out_load)
            begin
                total_reg    <= '0;
                pad_reg      <= 1'b0;
                idx_reg      <= '0;
                len_done_reg <= 1'b0;
            end
        end
    end

    // Round unit
    sha256mh_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .w_we       (we),
        .w_addr     (idx_reg),
        .w_data     (wdat),
        .init_words (init_reg),
        .hash_words (hash_w)
    );

    // Output register: pair p in bits [64p +: 64], even word in upper half
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            digest_reg    <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            ovf_reg       <= total_reg[32];
            for (int p = 0; p < 4; p++)
            begin
                digest_reg[64*p+32 +: 32] <= total_reg[32] ? 32'd0 : hash_w[2*p];
                digest_reg[64*p +: 32]    <= total_reg[32] ? 32'd0 : hash_w[2*p+1];
            end
        end
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = digest_reg;
    assign m_tuser  = ovf_reg;

    // Assertions
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("digest dropped while stalled");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> $past(rnd_reg) == 6'd63)
        else $error("fold before round 63");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("digest changed while stalled");

endmodule
`default_nettype wire

// ===== test/sha256_message_hasher_unit_test.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams whole messages into the hasher under random source and sink stalls
// and checks every digest against a cycle-free SHA-256 model kept in the
// bench. Known digests (empty message, "abc") are typed in; everything else
// comes from the model. Initial hash words are reprogrammed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sha256_message_hasher_unit_test;

    localparam int NUM_ITEMS   = 1750;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 200;
    localparam int LONG_HOLD   = 400;
    localparam logic [32:0] BYTE_LIMIT = 33'h1_0000_0000;

    typedef struct {
        logic [255:0] pairs;
        logic         overflow;
    } digest_rec_t;

    typedef struct {
        sha256mh_pkg::word_t data;
        logic [2:0]          count;
        logic                last;
        logic                known;
        logic [255:0]        pairs;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;   // data_word[31:0], byte_count[34:32]
    logic         s_tlast = 1'b0; // last_word
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;        // high pair, second, third, low pair
    logic         m_tuser;        // length_overflow
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    // typed-in digest travels alongside the transfer it belongs to
    logic         row_known = 1'b0;
    logic [255:0] row_pairs = '0;

    sha256_message_hasher_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // SHA-256 model state
    // ------------------------------------------------------------------
    sha256mh_pkg::word_t init_regs [8];
    sha256mh_pkg::word_t chain [8];
    sha256mh_pkg::word_t sched [16];
    int          word_slot;
    logic [32:0] byte_total;

    digest_rec_t pending_digests [$];
    int          mismatches = 0;
    int          digests_seen = 0;
    int          words_sent = 0;
    int          msgs_sent = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    bit          rx_fast = 1'b0;
    bit          tx_fast = 1'b0;

    function automatic sha256mh_pkg::word_t ror(input sha256mh_pkg::word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void mix_block();
        sha256mh_pkg::word_t v [8];
        sha256mh_pkg::word_t t1, t2, lo, hi, wt;
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int r = 0; r < 64; r++)
        begin
            if (r >= 16)
            begin
                lo = ror(sched[(r-15)&15], 7) ^ ror(sched[(r-15)&15], 18)
                     ^ (sched[(r-15)&15] >> 3);
                hi = ror(sched[(r-2)&15], 17) ^ ror(sched[(r-2)&15], 19)
                     ^ (sched[(r-2)&15] >> 10);
                sched[r&15] = sched[r&15] + lo + sched[(r-7)&15] + hi;
            end
            wt = sched[r&15];
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256mh_pkg::ROUND_K[r] + wt;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function automatic void absorb_word(input sha256mh_pkg::word_t w);
        sched[word_slot] = w;
        word_slot++;
        if (word_slot == 16)
        begin
            mix_block();
            word_slot = 0;
        end
    endfunction

    // one message word in; returns 1 when a digest falls out
    function automatic bit hash_word(input sha256mh_pkg::word_t data, input logic [2:0] cnt,
                                     input logic last, output digest_rec_t rec);
        int                  n;
        sha256mh_pkg::word_t keep;
        logic [63:0]         bits;
        n = (cnt > 4 || !last) ? 4 : cnt;
        if (byte_total == 0)
            for (int i = 0; i < 8; i++) chain[i] = init_regs[i];
        byte_total = byte_total + n;
        if (byte_total > BYTE_LIMIT) byte_total = BYTE_LIMIT;
        if (!last)
        begin
            absorb_word(data);
            return 1'b0;
        end
        // padding: 0x80 marker, zero fill, 64-bit bit length
        if (n == 4)
        begin
            absorb_word(data);
            absorb_word(32'h8000_0000);
        end
        else
        begin
            keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8*n));
            absorb_word((data & keep) | (32'h80 << (24 - 8*n)));
        end
        if (word_slot > 14)
            while (word_slot != 0) absorb_word(32'h0);
        while (word_slot < 14) absorb_word(32'h0);
        bits = {29'h0, byte_total[31:0], 3'b000};
        absorb_word(bits[63:32]);
        absorb_word(bits[31:0]);
        rec.overflow = (byte_total >= BYTE_LIMIT);
        rec.pairs = rec.overflow ? '0 : {chain[6], chain[7], chain[4], chain[5],
                                         chain[2], chain[3], chain[0], chain[1]};
        byte_total = '0;
        word_slot = 0;
        return 1'b1;
    endfunction

    initial
    begin
        for (int i = 0; i < 8; i++) init_regs[i] = sha256mh_pkg::STD_INIT[i];
        for (int i = 0; i < 16; i++) sched[i] = '0;
        word_slot = 0;
        byte_total = '0;
    end

    // ------------------------------------------------------------------
    // Monitors: all sample pre-edge values at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        digest_rec_t rec;
        digest_rec_t exp_rec;
        if (cfg_we)
            init_regs[cfg_index] = cfg_data;
        if (s_tvalid && s_tready)
        begin
            if (hash_word(s_tdata[31:0], s_tdata[34:32], s_tlast, rec))
            begin
                if (row_known) rec.pairs = row_pairs;
                pending_digests.push_back(rec);
            end
        end
        if (m_tvalid && m_tready)
        begin
            digests_seen++;
            if (pending_digests.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest transfer %h", m_tdata);
            end
            else
            begin
                exp_rec = pending_digests.pop_front();
                for (int p = 0; p < 4; p++)
                    if (m_tdata[64*p +: 64] !== exp_rec.pairs[64*p +: 64])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest %0d pair %0d: expected %h, got %h", digests_seen,
                                     p, exp_rec.pairs[64*p +: 64], m_tdata[64*p +: 64]);
                    end
                if (m_tuser !== exp_rec.overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest %0d overflow: expected %b, got %b", digests_seen,
                                 exp_rec.overflow, m_tuser);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Digest sink with random back-pressure and one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int  n;
        bit  got;
        @(posedge rst_n);
        forever
        begin
            if (hold_req) n = LONG_HOLD;
            else if ($urandom_range(0, 31) == 0) n = 0;
            else n = rx_fast ? 0 : $urandom_range(0, 15);
            hold_req = 1'b0;
            if ($urandom_range(0, 19) == 0) rx_fast = ~rx_fast;
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = m_tvalid;
                @(posedge clk);
            end while (!got);
        end
    end

    // ------------------------------------------------------------------
    // Word source
    // ------------------------------------------------------------------
    task automatic send_word(input sha256mh_pkg::word_t data, input logic [2:0] cnt,
                             input logic last, input logic known, input logic [255:0] pairs);
        int gap;
        bit got;
        gap = tx_fast ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {5'b0, cnt, data};
        s_tlast   <= last;
        row_known <= known;
        row_pairs <= pairs;
        do
        begin
            @(negedge clk);
            got = s_tready;
            @(posedge clk);
        end while (!got);
        words_sent++;
        if (last) msgs_sent++;
    endtask

    // source idle until every expected digest has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_digests.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic load_init_words(input sha256mh_pkg::word_t vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_message(input int body_words);
        logic [2:0] cnt;
        for (int i = 0; i < body_words; i++)
        begin
            // now and then a short or oversized count on a middle word
            cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_word($urandom, cnt, 1'b0, 1'b0, '0);
        end
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
    endtask

    initial
    begin
        stim_row_t           rows [$];
        stim_row_t           row;
        sha256mh_pkg::word_t vals [8];
        int                  body;

        // directed rows: known digests, count extremes, two-block padding
        rows.push_back('{32'h0, 3'd0, 1'b1, 1'b1,
            {64'ha495991b7852b855, 64'h27ae41e4649b934c,
             64'h9afbf4c8996fb924, 64'he3b0c44298fc1c14}});
        rows.push_back('{32'h61626300, 3'd3, 1'b1, 1'b1,
            {64'hb410ff61f20015ad, 64'hb00361a396177a9c,
             64'h414140de5dae2223, 64'hba7816bf8f01cfea}});
        rows.push_back('{32'hffffffff, 3'd4, 1'b1, 1'b0, '0});
        rows.push_back('{32'h12345678, 3'd7, 1'b1, 1'b0, '0});
        rows.push_back('{32'h00000000, 3'd2, 1'b0, 1'b0, '0});
        rows.push_back('{32'hdeadbeef, 3'd1, 1'b1, 1'b0, '0});
        rows.push_back('{32'hffffffff, 3'd5, 1'b0, 1'b0, '0});
        rows.push_back('{32'h0badf00d, 3'd6, 1'b1, 1'b0, '0});
        // 14 full words then a full last word: length spills into a second block
        for (int i = 0; i < 15; i++)
            rows.push_back('{32'h01010101 * (i + 1), 3'd4, (i == 14), 1'b0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            row = rows[i];
            send_word(row.data, row.count, row.last, row.known, row.pairs);
        end

        // random messages, with init word phases in between
        while (words_sent < NUM_ITEMS)
        begin
            if (msgs_sent == 30)
                hold_req = 1'b1;
            if (msgs_sent == 50)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                wait (pending_digests.size() == 0);
            end
            if (msgs_sent == 20 || msgs_sent == 40 || msgs_sent == 60 || msgs_sent == 80)
            begin
                drain_results();
                for (int i = 0; i < 8; i++)
                    case (msgs_sent)
                        20:      vals[i] = 32'h0;
                        40:      vals[i] = 32'hffff_ffff;
                        60:      vals[i] = $urandom;
                        default: vals[i] = sha256mh_pkg::STD_INIT[i];
                    endcase
                load_init_words(vals);
            end
            tx_fast = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0:       body = $urandom_range(41, 70);
                1, 2, 3: body = $urandom_range(21, 40);
                default: body = $urandom_range(0, 20);
            endcase
            send_message(body);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        wait (pending_digests.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d words in %0d messages, %0d digests checked", words_sent,
                 msgs_sent, digests_seen);
        $display("init words: standard, all zero, all one, random, standard again");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sha256_message_hasher_unit.f =====
rtl/core/sha256mh_pkg.sv
rtl/core/sha256mh_round.sv
rtl/core/sha256_message_hasher_unit.sv
test/sha256_message_hasher_unit_test.sv
